@@ src/y86rab_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// y86rab_pkg
// Shared types, codes and constants for the Y86 register/ALU/branch unit.
// ---------------------------------------------------------------------------
package y86rab_pkg;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegAw    = $clog2(NumRegs);
  localparam int unsigned DataW    = 32;

  localparam logic [3:0] RegNone   = 4'd15;
  localparam logic [3:0] FuncZero  = 4'd0;

  localparam logic [2:0] LenRr     = 3'd2;
  localparam logic [2:0] LenIr     = 3'd6;
  localparam logic [2:0] LenJmp    = 3'd5;
  localparam logic [2:0] LenErr    = 3'd0;

  typedef enum logic [1:0] {
    MODE_RRMOVL = 2'd0,
    MODE_IRMOVL = 2'd1,
    MODE_ALU    = 2'd2,
    MODE_JUMP   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ALU_ADD = 4'd0,
    ALU_SUB = 4'd1,
    ALU_AND = 4'd2,
    ALU_XOR = 4'd3,
    ALU_MUL = 4'd4,
    ALU_CMP = 4'd5
  } alu_func_e;

  typedef enum logic [3:0] {
    JMP_ALWAYS = 4'd0,
    JMP_LE     = 4'd1,
    JMP_LT     = 4'd2,
    JMP_EQ     = 4'd3,
    JMP_NE     = 4'd4,
    JMP_GE     = 4'd5,
    JMP_GT     = 4'd6
  } jmp_cond_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_REG  = 2'd1,
    STAT_BAD_FUNC = 2'd2
  } status_e;

  typedef struct packed {
    logic zf;
    logic sf;
    logic of;
  } flags_t;

  typedef struct packed {
    logic [DataW-1:0] write_value;
    logic             write_enable;
    flags_t           flags;
    logic             branch_taken;
    logic [2:0]       length_bytes;
    status_e          status;
  } result_t;

endpackage
`default_nettype wire

@@ src/y86rab_regfile.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// y86rab_regfile
// Register file memory: one write port, two registered read ports, per-entry
// valid bits for the reset image and a bypass for a same-edge write.
// ---------------------------------------------------------------------------
module y86rab_regfile (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          rd_en_i,
  input  wire logic [y86rab_pkg::RegAw-1:0]  rd_addr_a_i,
  input  wire logic [y86rab_pkg::RegAw-1:0]  rd_addr_b_i,
  input  wire logic                          wr_en_i,
  input  wire logic [y86rab_pkg::RegAw-1:0]  wr_addr_i,
  input  wire logic [y86rab_pkg::DataW-1:0]  wr_data_i,
  output logic      [y86rab_pkg::DataW-1:0]  rd_data_a_o,
  output logic      [y86rab_pkg::DataW-1:0]  rd_data_b_o
);

  logic [y86rab_pkg::DataW-1:0] mem [y86rab_pkg::NumRegs];
  logic [y86rab_pkg::NumRegs-1:0] vld_q;

  logic [y86rab_pkg::DataW-1:0] rd_a_q, rd_b_q, fwd_data_q;
  logic [y86rab_pkg::RegAw-1:0] addr_a_q, addr_b_q;
  logic                         vld_a_q, vld_b_q, fwd_a_q, fwd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // Read data is sampled before a write at the same edge lands; catch it.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q     <= mem[rd_addr_a_i];
      rd_b_q     <= mem[rd_addr_b_i];
      addr_a_q   <= rd_addr_a_i;
      addr_b_q   <= rd_addr_b_i;
      vld_a_q    <= vld_q[rd_addr_a_i];
      vld_b_q    <= vld_q[rd_addr_b_i];
      fwd_a_q    <= wr_en_i && (wr_addr_i == rd_addr_a_i);
      fwd_b_q    <= wr_en_i && (wr_addr_i == rd_addr_b_i);
      fwd_data_q <= wr_data_i;
    end
  end

  // Never-written entries read as their own index.
  always_comb begin
    if (fwd_a_q) begin
      rd_data_a_o = fwd_data_q;
    end else if (vld_a_q) begin
      rd_data_a_o = rd_a_q;
    end else begin
      rd_data_a_o = {{(y86rab_pkg::DataW-y86rab_pkg::RegAw){1'b0}}, addr_a_q};
    end
    if (fwd_b_q) begin
      rd_data_b_o = fwd_data_q;
    end else if (vld_b_q) begin
      rd_data_b_o = rd_b_q;
    end else begin
      rd_data_b_o = {{(y86rab_pkg::DataW-y86rab_pkg::RegAw){1'b0}}, addr_b_q};
    end
  end

endmodule
`default_nettype wire

@@ src/y86rab_exec.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// y86rab_exec
// Execute logic: decode checks, ALU with flags, branch condition and
// instruction length for one instruction.
// ---------------------------------------------------------------------------
module y86rab_exec (
  input  wire logic [1:0]                   mode_i,
  input  wire logic [3:0]                   func_i,
  input  wire logic [3:0]                   reg_a_i,
  input  wire logic [3:0]                   reg_b_i,
  input  wire logic [y86rab_pkg::DataW-1:0] immediate_i,
  input  wire logic [y86rab_pkg::DataW-1:0] op_a_i,
  input  wire logic [y86rab_pkg::DataW-1:0] op_b_i,
  input  wire y86rab_pkg::flags_t           flags_i,
  output y86rab_pkg::result_t               res_o
);

  logic [y86rab_pkg::DataW-1:0]   sum, diff, alu_r;
  logic signed [2*y86rab_pkg::DataW-1:0] prod;
  logic                           add_of, sub_of, mul_of, alu_of, lt, cond;
  logic                           regs_bad;

  assign sum    = op_b_i + op_a_i;
  assign diff   = op_b_i - op_a_i;
  assign prod   = $signed(op_b_i) * $signed(op_a_i);
  assign add_of = ~(op_b_i[31] ^ op_a_i[31]) & (op_b_i[31] ^ sum[31]);
  assign sub_of = (op_b_i[31] ^ op_a_i[31]) & (op_b_i[31] ^ diff[31]);
  // Product fits when the top 33 bits are all equal.
  assign mul_of = !((&prod[63:31]) || !(|prod[63:31]));
  assign lt     = flags_i.sf ^ flags_i.of;
  assign regs_bad = reg_a_i[3] || reg_b_i[3];

  always_comb begin
    alu_r  = diff;
    alu_of = flags_i.of;
    case (func_i)
      y86rab_pkg::ALU_ADD: begin
        alu_r  = sum;
        alu_of = add_of;
      end
      y86rab_pkg::ALU_SUB: begin
        alu_r  = diff;
        alu_of = sub_of;
      end
      y86rab_pkg::ALU_AND: alu_r = op_b_i & op_a_i;
      y86rab_pkg::ALU_XOR: alu_r = op_b_i ^ op_a_i;
      y86rab_pkg::ALU_MUL: begin
        alu_r  = prod[31:0];
        alu_of = mul_of;
      end
      default: begin
        alu_r  = diff;
        alu_of = flags_i.of;
      end
    endcase
  end

  always_comb begin
    cond = 1'b0;
    case (func_i)
      y86rab_pkg::JMP_ALWAYS: cond = 1'b1;
      y86rab_pkg::JMP_LE:     cond = lt || flags_i.zf;
      y86rab_pkg::JMP_LT:     cond = lt;
      y86rab_pkg::JMP_EQ:     cond = flags_i.zf;
      y86rab_pkg::JMP_NE:     cond = !flags_i.zf;
      y86rab_pkg::JMP_GE:     cond = !lt;
      y86rab_pkg::JMP_GT:     cond = !lt && !flags_i.zf;
      default:                cond = 1'b0;
    endcase
  end

  always_comb begin
    res_o              = '0;
    res_o.flags        = flags_i;
    res_o.status       = y86rab_pkg::STAT_OK;
    res_o.length_bytes = y86rab_pkg::LenErr;
    case (mode_i)
      y86rab_pkg::MODE_RRMOVL: begin
        if (func_i != y86rab_pkg::FuncZero) begin
          res_o.status = y86rab_pkg::STAT_BAD_FUNC;
        end else if (regs_bad) begin
          res_o.status = y86rab_pkg::STAT_BAD_REG;
        end else begin
          res_o.write_value  = op_a_i;
          res_o.write_enable = 1'b1;
          res_o.length_bytes = y86rab_pkg::LenRr;
        end
      end
      y86rab_pkg::MODE_IRMOVL: begin
        if (func_i != y86rab_pkg::FuncZero) begin
          res_o.status = y86rab_pkg::STAT_BAD_FUNC;
        end else if (reg_a_i != y86rab_pkg::RegNone || reg_b_i[3]) begin
          res_o.status = y86rab_pkg::STAT_BAD_REG;
        end else begin
          res_o.write_value  = immediate_i;
          res_o.write_enable = 1'b1;
          res_o.length_bytes = y86rab_pkg::LenIr;
        end
      end
      y86rab_pkg::MODE_ALU: begin
        if (regs_bad) begin
          res_o.status = y86rab_pkg::STAT_BAD_REG;
        end else if (!(func_i inside {[y86rab_pkg::ALU_ADD:y86rab_pkg::ALU_CMP]})) begin
          res_o.status = y86rab_pkg::STAT_BAD_FUNC;
        end else begin
          res_o.flags.zf     = (alu_r == '0);
          res_o.flags.sf     = alu_r[31];
          res_o.flags.of     = alu_of;
          res_o.length_bytes = y86rab_pkg::LenRr;
          // Compare only sets flags.
          if (func_i != y86rab_pkg::ALU_CMP) begin
            res_o.write_value  = alu_r;
            res_o.write_enable = 1'b1;
          end
        end
      end
      y86rab_pkg::MODE_JUMP: begin
        if (func_i inside {[y86rab_pkg::JMP_ALWAYS:y86rab_pkg::JMP_GT]}) begin
          res_o.branch_taken = cond;
          res_o.length_bytes = y86rab_pkg::LenJmp;
        end else begin
          res_o.status = y86rab_pkg::STAT_BAD_FUNC;
        end
      end
      default: res_o.status = y86rab_pkg::STAT_BAD_FUNC;
    endcase
  end

endmodule
`default_nettype wire

@@ src/y86_register_alu_branch_unit.sv @@
`default_nettype none
// Throughput: one instruction per cycle while the output is not stalled; each
// beat passes stage 1 and then the output register. The register file read is
// issued at accept and the execute/write-back stage commits as its result moves out.
// Reset: flags clear, pipeline empties, register file valid bits clear so
// entry i reads as i until first written; no clearing pass is needed.
// ---------------------------------------------------------------------------
// y86_register_alu_branch_unit
// Y86 execute unit: moves, ALU ops with ZF/SF/OF and conditional jumps over
// an eight-entry register file.
// ---------------------------------------------------------------------------
module y86_register_alu_branch_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic [3:0]         func_i,
  input  wire logic [3:0]         reg_a_i,
  input  wire logic [3:0]         reg_b_i,
  input  wire logic signed [31:0] immediate_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      write_value_o,
  output logic                    write_enable_o,
  output logic                    zero_flag_o,
  output logic                    sign_flag_o,
  output logic                    overflow_flag_o,
  output logic                    branch_taken_o,
  output logic [2:0]              length_bytes_o,
  output logic [1:0]              status_o
);

  logic                          accept, adv1;
  logic                          s1_valid_q, out_valid_q;
  logic [1:0]                    s1_mode_q;
  logic [3:0]                    s1_func_q, s1_reg_a_q, s1_reg_b_q;
  logic [y86rab_pkg::DataW-1:0]  s1_imm_q;
  logic [y86rab_pkg::DataW-1:0]  op_a, op_b;
  y86rab_pkg::flags_t            flags_q;
  y86rab_pkg::result_t           res, out_res_q;

  assign adv1       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv1;
  assign accept     = in_valid_i && !in_stall_o;

  y86rab_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_a_i (reg_a_i[y86rab_pkg::RegAw-1:0]),
    .rd_addr_b_i (reg_b_i[y86rab_pkg::RegAw-1:0]),
    .wr_en_i     (adv1 && res.write_enable),
    .wr_addr_i   (s1_reg_b_q[y86rab_pkg::RegAw-1:0]),
    .wr_data_i   (res.write_value),
    .rd_data_a_o (op_a),
    .rd_data_b_o (op_b)
  );

  y86rab_exec u_exec (
    .mode_i      (s1_mode_q),
    .func_i      (s1_func_q),
    .reg_a_i     (s1_reg_a_q),
    .reg_b_i     (s1_reg_b_q),
    .immediate_i (s1_imm_q),
    .op_a_i      (op_a),
    .op_b_i      (op_b),
    .flags_i     (flags_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv1) begin
        s1_valid_q <= 1'b0;
      end
      if (adv1) begin
        out_valid_q <= 1'b1;
        flags_q     <= res.flags;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold unless a new beat moves in.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q  <= mode_i;
      s1_func_q  <= func_i;
      s1_reg_a_q <= reg_a_i;
      s1_reg_b_q <= reg_b_i;
      s1_imm_q   <= immediate_i;
    end
    if (adv1) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_value_o   = out_res_q.write_value;
  assign write_enable_o  = out_res_q.write_enable;
  assign zero_flag_o     = out_res_q.flags.zf;
  assign sign_flag_o     = out_res_q.flags.sf;
  assign overflow_flag_o = out_res_q.flags.of;
  assign branch_taken_o  = out_res_q.branch_taken;
  assign length_bytes_o  = out_res_q.length_bytes;
  assign status_o        = out_res_q.status;

endmodule
`default_nettype wire
